// ----- hdl/bpc_pkg.sv -----
// Shared types, codes and constants of the button press classifier.
`default_nettype none

package bpc_pkg;

   localparam int TIME_BITS = 32;

   typedef logic [TIME_BITS-1:0] time_type;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // Register indexes of the write port.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LONG_PRESS      = 3'd0,
      CSR_DOUBLE_SHORT    = 3'd1,
      CSR_DOUBLE_LONG_TMO = 3'd2,
      CSR_DEBOUNCE        = 3'd3,
      CSR_REPEAT_DELAY    = 3'd4
   } csr_index_type;

   localparam logic [15:0] LONG_PRESS_RST      = 16'd400;
   localparam logic [15:0] DOUBLE_SHORT_RST    = 16'd0;
   localparam logic [15:0] DOUBLE_LONG_TMO_RST = 16'd0;
   localparam logic [7:0]  DEBOUNCE_RST        = 8'd50;
   localparam logic [15:0] REPEAT_DELAY_RST    = 16'd250;

   typedef enum logic [2:0] {
      EV_SHORT_SINGLE = 3'd0,
      EV_SHORT_DOUBLE = 3'd1,
      EV_LONG_REPEAT  = 3'd2,
      EV_LONG_END     = 3'd3,
      EV_DOUBLE_LONG  = 3'd4,
      EV_DL_TIMEOUT   = 3'd5,
      EV_STAY_AWAKE   = 3'd6
   } event_code_type;

   // Press phase: one-hot.
   typedef enum logic [2:0] {
      PH_NONE  = 3'b001,
      PH_SHORT = 3'b010,
      PH_LONG  = 3'b100
   } phase_type;

   typedef struct packed {
      logic edge_seen;
      logic new_level;
   } req_type;

   typedef struct packed {
      event_code_type event_code;
      logic           last_of_tick;
   } rsp_type;

   // Events of one tick, in order, handed from the classifier to the queue.
   typedef struct packed {
      logic [1:0]     count;
      event_code_type code0;
      event_code_type code1;
   } evt_bundle_type;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

endpackage

`default_nettype wire

// ----- hdl/bpc_core.sv -----
// Classifier state, configuration registers and per-tick event decision.
`default_nettype none

module bpc_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              tick_accept,
   input  wire bpc_pkg::req_type                  req_data,
   input  wire logic                              csr_write_en,
   input  wire logic [bpc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [bpc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output bpc_pkg::evt_bundle_type                evt_bundle
);
   import bpc_pkg::*;

   logic [15:0] long_press_ff;
   logic [15:0] double_short_ff;
   logic [15:0] double_long_tmo_ff;
   logic [7:0]  debounce_ff;
   logic [15:0] repeat_delay_ff;

   // tick_ff holds the time the next tick will carry (model now + 1).
   time_type  tick_ff,        tick_in;
   time_type  edge_time_ff,   edge_time_in;
   logic      edge_pending_ff, edge_pending_in;
   logic      level_ff,       level_in;
   time_type  press_len_ff,   press_len_in;
   time_type  repeat_ref_ff,  repeat_ref_in;
   time_type  long_ref_ff,    long_ref_in;
   time_type  short_ref_ff,   short_ref_in;
   phase_type phase_ff,       phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff      <= LONG_PRESS_RST;
         double_short_ff    <= DOUBLE_SHORT_RST;
         double_long_tmo_ff <= DOUBLE_LONG_TMO_RST;
         debounce_ff        <= DEBOUNCE_RST;
         repeat_delay_ff    <= REPEAT_DELAY_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LONG_PRESS:      long_press_ff      <= csr_wdata;
            CSR_DOUBLE_SHORT:    double_short_ff    <= csr_wdata;
            CSR_DOUBLE_LONG_TMO: double_long_tmo_ff <= csr_wdata;
            CSR_DEBOUNCE:        debounce_ff        <= csr_wdata[7:0];
            CSR_REPEAT_DELAY:    repeat_delay_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      time_type       now;
      time_type       since_edge;
      logic           dl_tmo;
      logic           main_vld;
      event_code_type main_code;
      logic           stay;
      phase_type      phase_mid;

      now       = tick_ff;
      tick_in   = tick_ff + time_type'(1);

      level_in        = req_data.edge_seen ? req_data.new_level : level_ff;
      edge_time_in    = req_data.edge_seen ? now : edge_time_ff;
      edge_pending_in = req_data.edge_seen | edge_pending_ff;

      press_len_in  = press_len_ff;
      repeat_ref_in = repeat_ref_ff;
      long_ref_in   = long_ref_ff;
      short_ref_in  = short_ref_ff;

      main_vld  = 1'b0;
      main_code = EV_STAY_AWAKE;
      stay      = 1'b0;

      since_edge = now - edge_time_in;

      // Double-long window expired while released.
      dl_tmo = !level_in && (phase_ff == PH_LONG) &&
               ((now - long_ref_ff) >= time_type'(double_long_tmo_ff));
      phase_mid = dl_tmo ? PH_NONE : phase_ff;
      phase_in  = phase_mid;

      if (!((!edge_pending_in && (press_len_ff == '0)) ||
            (since_edge < time_type'(debounce_ff)))) begin
         edge_pending_in = 1'b0;
         if (level_in) begin
            press_len_in = since_edge;
            if (since_edge >= time_type'(long_press_ff)) begin
               if (phase_mid == PH_LONG) begin
                  phase_in     = PH_NONE;
                  press_len_in = '0;
                  main_vld     = 1'b1;
                  main_code    = EV_DOUBLE_LONG;
               end else begin
                  long_ref_in = now;
                  if (repeat_ref_ff == '0) begin
                     repeat_ref_in = now;
                  end else if ((now - repeat_ref_ff) >= time_type'(repeat_delay_ff)) begin
                     main_vld      = 1'b1;
                     main_code     = EV_LONG_REPEAT;
                     repeat_ref_in = now;
                  end
               end
            end
            stay = 1'b1;
         end else if (press_len_ff != '0) begin
            repeat_ref_in = '0;
            press_len_in  = '0;
            if (phase_mid == PH_LONG) begin
               phase_in  = PH_NONE;
               main_vld  = 1'b1;
               main_code = EV_DL_TIMEOUT;
            end else if (press_len_ff >= time_type'(long_press_ff)) begin
               if (double_long_tmo_ff != '0) begin
                  phase_in = PH_LONG;
               end else begin
                  main_vld  = 1'b1;
                  main_code = EV_LONG_END;
               end
            end else if ((phase_mid == PH_SHORT) &&
                         ((now - short_ref_ff) < time_type'(double_short_ff))) begin
               phase_in  = PH_NONE;
               main_vld  = 1'b1;
               main_code = EV_SHORT_DOUBLE;
            end else begin
               phase_in     = PH_SHORT;
               short_ref_in = now;
               if (double_short_ff == '0) begin
                  main_vld  = 1'b1;
                  main_code = EV_SHORT_SINGLE;
               end
            end
         end
      end

      // Pack the events in order: timeout, main event, stay awake.
      evt_bundle.count = 2'(dl_tmo) + 2'(main_vld) + 2'(stay);
      evt_bundle.code0 = dl_tmo ? EV_DL_TIMEOUT : (main_vld ? main_code : EV_STAY_AWAKE);
      evt_bundle.code1 = (dl_tmo && main_vld) ? main_code : EV_STAY_AWAKE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= time_type'(1);
         edge_time_ff    <= '0;
         edge_pending_ff <= 1'b0;
         level_ff        <= 1'b0;
         press_len_ff    <= '0;
         repeat_ref_ff   <= '0;
         long_ref_ff     <= '0;
         short_ref_ff    <= '0;
         phase_ff        <= PH_NONE;
      end else if (tick_accept) begin
         tick_ff         <= tick_in;
         edge_time_ff    <= edge_time_in;
         edge_pending_ff <= edge_pending_in;
         level_ff        <= level_in;
         press_len_ff    <= press_len_in;
         repeat_ref_ff   <= repeat_ref_in;
         long_ref_ff     <= long_ref_in;
         short_ref_ff    <= short_ref_in;
         phase_ff        <= phase_in;
      end
   end

   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> tick_ff == $past(tick_ff) + time_type'(1))
      else $error("tick counter did not advance on an accepted beat");

   a_edge_stamp: assert property (@(posedge clock) disable iff (reset)
      tick_accept && req_data.edge_seen |=> edge_time_ff == $past(tick_ff))
      else $error("edge time not stamped with the tick time");

   a_stay_held: assert property (@(posedge clock) disable iff (reset)
      tick_accept && (evt_bundle.count != 2'd0) &&
      ((evt_bundle.code0 == EV_STAY_AWAKE) ||
       ((evt_bundle.count == 2'd2) && (evt_bundle.code1 == EV_STAY_AWAKE)))
      |=> level_ff)
      else $error("stay-awake issued while the button is released");

endmodule

`default_nettype wire

// ----- hdl/bpc_evq.sv -----
// Event queue: up to two events in per tick; one beat out per unstalled cycle.
`default_nettype none

module bpc_evq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire bpc_pkg::evt_bundle_type evt_bundle,
   output logic                         full2,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output bpc_pkg::rsp_type             rsp_data
);
   import bpc_pkg::*;

   rsp_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] cnt_ff,    cnt_in;
   logic [QUEUE_CNT_BITS-1:0] n_push;
   logic                      pop;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_nx1;

   assign n_push     = push ? QUEUE_CNT_BITS'(evt_bundle.count) : '0;
   assign pop        = rsp_valid && !rsp_stall;
   assign wr_ptr_nx1 = wr_ptr_ff + QUEUE_PTR_BITS'(1);
   assign wr_ptr_in  = wr_ptr_ff + QUEUE_PTR_BITS'(n_push);
   assign rd_ptr_in  = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
   assign cnt_in     = cnt_ff + n_push - QUEUE_CNT_BITS'(pop);

   // Stall the input unless room for a full tick's worth of events remains.
   assign full2     = cnt_ff > QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (n_push != '0) begin
         mem_ff[wr_ptr_ff] <= '{event_code: evt_bundle.code0,
                                last_of_tick: (evt_bundle.count == 2'd1)};
      end
      if (n_push == QUEUE_CNT_BITS'(2)) begin
         mem_ff[wr_ptr_nx1] <= '{event_code: evt_bundle.code1, last_of_tick: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("event queue overflow");

   a_empty_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !full2)
      else $error("empty queue stalls the input");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      QUEUE_PTR_BITS'(cnt_ff) == QUEUE_PTR_BITS'(wr_ptr_ff - rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

// ----- hdl/button_press_classifier.sv -----
// Top level of the button press classifier: classifier core plus event queue.
//
//   channel  direction  handshake               beat
//   req_     in         req_valid / req_stall   one millisecond tick (edge_seen, new_level)
//   rsp_     out        rsp_valid / rsp_stall   one event (event_code, last_of_tick)
//   csr_     in         csr_write_en            register write, no wait, no read-back
//
// Each tick is classified in the cycle it is accepted; its zero to two events
// land in a four-entry queue and leave from the next cycle on, one beat per cycle
// while rsp_stall is low. A tick is accepted every cycle while the queue holds
// at most two events, so without rsp_stall ticks with at most one event flow at
// one tick per cycle; a run of two-event ticks is held back by the single event output.
// req_stall comes from the registered queue count only; rsp_stall never reaches it
// combinationally. Reset is synchronous: time, press state and queue clear,
// registers return to their defaults.
`default_nettype none

module button_press_classifier (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire bpc_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output bpc_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_write_en,
   input  wire logic [bpc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [bpc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import bpc_pkg::*;

   evt_bundle_type evt_bundle;
   logic           tick_accept;
   logic           queue_full2;

   // Accept a tick only when the queue can take both possible events.
   assign req_stall   = queue_full2;
   assign tick_accept = req_valid && !queue_full2;

   bpc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .tick_accept  (tick_accept),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .evt_bundle   (evt_bundle)
   );

   // Hold the tick's events until the consumer takes them.
   bpc_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .push       (tick_accept),
      .evt_bundle (evt_bundle),
      .full2      (queue_full2),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_button_press_classifier.sv -----
// Self-checking testbench of the button press classifier: directed table, random presses.
`default_nettype none

module tb_button_press_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   // Timing of the run: settle after a drain, tail at the end, hard cycle limit.
   localparam int DRAIN_CYCLES = 8;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int ERROR_SHOWN  = 10;
   localparam int NOT_TYPED    = -1;
   localparam int HOLD_CAP     = 48;
   localparam int PHASES       = 8;
   localparam int PHASE_TICKS  = 42;

   typedef enum logic {ROW_TICK, ROW_CFG} row_kind_type;

   // One row of the directed table: either a register write or one tick.
   // typed_n is the number of events read straight off the behavior
   // (zero or one), or NOT_TYPED to take the predictor's answer.
   typedef struct {
      row_kind_type   kind;
      csr_index_type  reg_idx;
      logic [15:0]    reg_val;
      logic           edge_seen;
      logic           new_level;
      int             typed_n;
      event_code_type typed_code;
   } dir_row_type;

   localparam int DIR_ROWS = 32;

   dir_row_type dir_table [DIR_ROWS] = '{
      // Defaults after reset: nothing is evaluated inside the 50 ms quiet time.
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, 0, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b1, 0, EV_SHORT_SINGLE},
      // Release before the press was evaluated: no events at all.
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b0, 0, EV_SHORT_SINGLE},
      '{ROW_CFG,  CSR_DEBOUNCE,        16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_CFG,  CSR_LONG_PRESS,      16'd3, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_CFG,  CSR_REPEAT_DELAY,    16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_CFG,  CSR_DOUBLE_SHORT,    16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_CFG,  CSR_DOUBLE_LONG_TMO, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      // No quiet time: a press is evaluated in its own tick with zero length,
      // gives one stay-awake and then evaluation stops until the next edge.
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b1, 1, EV_STAY_AWAKE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b1, 0, EV_SHORT_SINGLE},
      '{ROW_CFG,  CSR_DEBOUNCE,        16'd1, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      // Long hold, zero repeat delay: repeats on evaluated ticks past the first long one.
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b1, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b1, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b1, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      // Short press, single event since the double window is zero.
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b1, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b1, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_CFG,  CSR_DOUBLE_SHORT,   16'd20, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      // Two short presses inside the window.
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b1, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b1, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b1, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b1, 1'b0, NOT_TYPED, EV_SHORT_SINGLE},
      '{ROW_TICK, CSR_LONG_PRESS, 16'd0, 1'b0, 1'b0, NOT_TYPED, EV_SHORT_SINGLE}
   };

   // DUT signals; the inputs are all known from time zero.
   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_stall;
   req_type       req_data     = '0;
   logic          rsp_valid;
   logic          rsp_stall    = 1'b0;
   rsp_type       rsp_data;
   logic          csr_write_en = 1'b0;
   csr_index_type csr_index    = CSR_LONG_PRESS;
   logic [15:0]   csr_wdata    = '0;

   // Idle percentages of the two sides, changed per phase.
   int req_pct = 0;
   int rsp_pct = 0;

   // Classifier shadow: registers and press state.
   logic [15:0] cfg_long       = LONG_PRESS_RST;
   logic [15:0] cfg_dshort     = DOUBLE_SHORT_RST;
   logic [15:0] cfg_dlong      = DOUBLE_LONG_TMO_RST;
   logic [7:0]  cfg_debounce   = DEBOUNCE_RST;
   logic [15:0] cfg_repeat     = REPEAT_DELAY_RST;
   time_type    ms_now         = '0;
   time_type    edge_stamp     = '0;
   logic        edge_waiting   = 1'b0;
   logic        held           = 1'b0;
   time_type    hold_len       = '0;
   time_type    repeat_stamp   = '0;
   time_type    long_stamp     = '0;
   time_type    short_stamp    = '0;
   phase_type   press_phase    = PH_NONE;

   event_code_type tick_events [$];
   rsp_type        pending_events [$];

   int ticks_sent      = 0;
   int regs_written    = 0;
   int events_checked  = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int seen_by_code [7];

   button_press_classifier i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Millisecond time since a stamp; the subtraction wraps at the time width.
   function automatic time_type elapsed(time_type stamp);
      return ms_now - stamp;
   endfunction

   // At most two events per tick; anything beyond is dropped.
   function automatic void note_event(event_code_type code);
      if (tick_events.size() < 2) tick_events.push_back(code);
   endfunction

   // Advance the shadow by one tick and collect the events it raises.
   task automatic classify_tick(input req_type d);
      tick_events.delete();
      ms_now = ms_now + 1'b1;
      if (d.edge_seen) begin
         held         = d.new_level;
         edge_stamp   = ms_now;
         edge_waiting = 1'b1;
      end

      // Released while waiting for a second long press: time out.
      if (!held && press_phase == PH_LONG && elapsed(long_stamp) >= cfg_dlong) begin
         press_phase = PH_NONE;
         note_event(EV_DL_TIMEOUT);
      end

      // Evaluate only after the quiet time, and only with something to look at.
      if (!((!edge_waiting && hold_len == 0) || elapsed(edge_stamp) < cfg_debounce)) begin
         edge_waiting = 1'b0;
         if (held) begin
            hold_len = elapsed(edge_stamp);
            if (hold_len >= cfg_long) begin
               if (press_phase == PH_LONG) begin
                  press_phase = PH_NONE;
                  hold_len    = '0;
                  note_event(EV_DOUBLE_LONG);
               end else begin
                  long_stamp = ms_now;
                  // A zero repeat stamp stands for idle, so re-arm instead of firing.
                  if (repeat_stamp == 0) begin
                     repeat_stamp = ms_now;
                  end else if (elapsed(repeat_stamp) >= cfg_repeat) begin
                     note_event(EV_LONG_REPEAT);
                     repeat_stamp = ms_now;
                  end
               end
            end
            note_event(EV_STAY_AWAKE);
         end else if (hold_len > 0) begin
            repeat_stamp = '0;
            if (press_phase == PH_LONG) begin
               press_phase = PH_NONE;
               note_event(EV_DL_TIMEOUT);
            end else if (hold_len >= cfg_long) begin
               if (cfg_dlong > 0) press_phase = PH_LONG;
               else note_event(EV_LONG_END);
            end else if (press_phase == PH_SHORT && elapsed(short_stamp) < cfg_dshort) begin
               press_phase = PH_NONE;
               note_event(EV_SHORT_DOUBLE);
            end else begin
               press_phase = PH_SHORT;
               short_stamp = ms_now;
               if (cfg_dshort == 0) note_event(EV_SHORT_SINGLE);
            end
            hold_len = '0;
         end
      end
   endtask

   // Drive one tick beat, wait for acceptance, then record what must come back.
   task automatic send_tick(input logic edge_seen, input logic new_level,
                            input int typed_n, input event_code_type typed_code);
      req_type d;
      d.edge_seen = edge_seen;
      d.new_level = new_level;
      // Sender idles cycle by cycle.
      while ($urandom_range(0, 99) < req_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
      classify_tick(d);
      if (typed_n == NOT_TYPED) begin
         foreach (tick_events[i])
            pending_events.push_back('{event_code: tick_events[i],
                                       last_of_tick: (i == tick_events.size() - 1)});
      end else if (typed_n > 0) begin
         pending_events.push_back('{event_code: typed_code, last_of_tick: 1'b1});
      end
   endtask

   task automatic tick(input logic edge_seen, input logic new_level);
      send_tick(edge_seen, new_level, NOT_TYPED, EV_SHORT_SINGLE);
   endtask

   // Drop valid, wait until every expected event is back, then settle.
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Register write, only with the block idle.
   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      drain_results(DRAIN_CYCLES);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      regs_written++;
      case (idx)
         CSR_LONG_PRESS:      cfg_long     = val;
         CSR_DOUBLE_SHORT:    cfg_dshort   = val;
         CSR_DOUBLE_LONG_TMO: cfg_dlong    = val;
         CSR_DEBOUNCE:        cfg_debounce = val[7:0];
         CSR_REPEAT_DELAY:    cfg_repeat   = val;
         default: ;
      endcase
   endtask

   // First the sender idles lightly and the receiver heavily, then the
   // reverse, then neither.
   task automatic set_idling(input int mode);
      case (mode)
         0:       begin req_pct = 34; rsp_pct = 71; end
         1:       begin req_pct = 71; rsp_pct = 34; end
         default: begin req_pct = 0;  rsp_pct = 0;  end
      endcase
   endtask

   // One phase: a register setting, fixed or random, then mostly well-formed presses
   // with random hold and gap lengths and some bouncing noise, or one long press.
   task automatic run_phase(input int p);
      int lp, ds, dl, db, rp;
      int stop_at, hold, gap, long_gap, short_max, k;
      bit held_off;
      held_off = 1'b0;
      case (p)
         0:       begin lp = 4;     ds = 0;     dl = 0;     db = 1;   rp = 2;     end
         1:       begin lp = 6;     ds = 8;     dl = 0;     db = 2;   rp = 3;     end
         2:       begin lp = 5;     ds = 0;     dl = 15;    db = 1;   rp = 1;     end
         3:       begin lp = 0;     ds = 0;     dl = 0;     db = 1;   rp = 1;     end
         4:       begin lp = 65535; ds = 65535; dl = 0;     db = 3;   rp = 65535; end
         5:       begin lp = 2;     ds = 0;     dl = 65535; db = 255; rp = 1;     end
         default: begin
            lp = $urandom_range(1, 12);
            ds = $urandom_range(0, 20);
            dl = $urandom_range(0, 1) ? $urandom_range(1, 30) : 0;
            db = $urandom_range(0, 4);
            rp = $urandom_range(1, 6);
         end
      endcase
      set_idling((p < 3) ? 0 : (p < 6) ? 1 : 2);
      write_reg(CSR_LONG_PRESS, lp[15:0]);
      write_reg(CSR_DOUBLE_SHORT, ds[15:0]);
      write_reg(CSR_DOUBLE_LONG_TMO, dl[15:0]);
      write_reg(CSR_DEBOUNCE, db[15:0]);
      write_reg(CSR_REPEAT_DELAY, rp[15:0]);

      if (db == 255) begin
         // Longest quiet time: one press that outlasts it; the release is
         // left pending into the next setting.
         tick(1'b1, 1'b1);
         repeat (259) tick(1'b0, 1'($urandom_range(0, 1)));
         tick(1'b1, 1'b0);
         repeat (3) tick(1'b0, 1'($urandom_range(0, 1)));
         return;
      end

      stop_at   = ticks_sent + PHASE_TICKS;
      short_max = (lp + db > 1) ? lp + db - 1 : 1;
      if (short_max > HOLD_CAP) short_max = HOLD_CAP;
      long_gap  = ds + dl + db + 8;
      if (long_gap > HOLD_CAP) long_gap = HOLD_CAP;

      while (ticks_sent < stop_at) begin
         // In phase 3, hold off once mid-phase until the block has emptied.
         if (p == 3 && !held_off && ticks_sent >= stop_at - PHASE_TICKS / 2) begin
            drain_results(0);
            held_off = 1'b1;
         end
         if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 1)) hold = $urandom_range(1, short_max);
            else hold = lp + db + $urandom_range(0, 2 * rp + 2);
            if (hold > HOLD_CAP) hold = HOLD_CAP;
            tick(1'b1, 1'b1);
            repeat (hold - 1) tick(1'b0, 1'($urandom_range(0, 1)));
            tick(1'b1, 1'b0);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6)
                                              : $urandom_range(1, long_gap);
            repeat (gap) tick(1'b0, 1'($urandom_range(0, 1)));
         end else begin
            k = $urandom_range(1, 6);
            repeat (k) tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Receiver: stall at random, check every accepted event beat against the
   // oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         events_checked++;
         if (int'(rsp_data.event_code) < 7) seen_by_code[int'(rsp_data.event_code)]++;
         if (pending_events.size() == 0) begin
            error_count++;
            if (error_count <= ERROR_SHOWN)
               $display("ERROR: unexpected event code=%0d last=%0b at cycle %0d",
                        rsp_data.event_code, rsp_data.last_of_tick, cycle_count);
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.event_code !== want.event_code ||
                rsp_data.last_of_tick !== want.last_of_tick) begin
               error_count++;
               if (error_count <= ERROR_SHOWN)
                  $display("ERROR: event mismatch at cycle %0d: code %0d/%0d last %0b/%0b",
                           cycle_count, rsp_data.event_code, want.event_code,
                           rsp_data.last_of_tick, want.last_of_tick);
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timeout with %0d events outstanding", pending_events.size());
         $display("tb_button_press_classifier NOT OK");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random phases, drain, verdict.
   initial begin
      foreach (seen_by_code[i]) seen_by_code[i] = 0;
      set_idling(0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CFG)
            write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
         else
            send_tick(dir_table[i].edge_seen, dir_table[i].new_level,
                      dir_table[i].typed_n, dir_table[i].typed_code);
      end

      for (int p = 0; p < PHASES; p++) run_phase(p);

      drain_results(TAIL_CYCLES);

      $display("Summary: %0d ticks over %0d register writes, %0d events compared",
               ticks_sent, regs_written, events_checked);
      $display("Summary: repeats %0d, long ends %0d, doubles %0d/%0d, timeouts %0d",
               seen_by_code[EV_LONG_REPEAT], seen_by_code[EV_LONG_END],
               seen_by_code[EV_SHORT_DOUBLE], seen_by_code[EV_DOUBLE_LONG],
               seen_by_code[EV_DL_TIMEOUT]);
      if (error_count == 0 && pending_events.size() == 0) begin
         $display("tb_button_press_classifier OK");
      end else begin
         $display("tb_button_press_classifier NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
